@@ rtl/dq_pkg.sv @@
// Types and constants shared by the circular deque modules.
// No dependencies.
package dq_pkg;

    localparam int WORD_W = 32;

    typedef enum logic [2:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_REAR  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_REAR   = 3'd3,
        REQ_READ       = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_LOAD = 4'b1000
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic read;
        logic load;
    } t_dp_cmd;

endpackage

@@ rtl/dq_ctrl.sv @@
// Sequencer for the circular deque: steps each request through execute,
// read and load, and owns the result valid flag. Depends on dq_pkg.
module dq_ctrl
    import dq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_READ;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

@@ rtl/dq_datapath.sv @@
// Datapath of the circular deque: head and tail pointers, empty flag, word
// store, read registers and result registers. Depends on dq_pkg.
module dq_datapath
    import dq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic [2:0]               i_req_type,
    input  logic signed [WORD_W-1:0] i_data_in,
    output logic signed [WORD_W-1:0] o_front_word,
    output logic signed [WORD_W-1:0] o_rear_word,
    output logic                     o_is_empty,
    output logic                     o_is_full,
    output logic [1:0]               o_status
);

    localparam int IW = $clog2(DEPTH);
    localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

    logic signed [WORD_W-1:0] r_mem [DEPTH];

    logic [2:0]               r_req;
    logic signed [WORD_W-1:0] r_data;
    logic [IW-1:0]            r_head, n_head;
    logic [IW-1:0]            r_tail, n_tail;
    logic                     r_empty, n_empty;
    t_status                  r_status, n_status;
    logic signed [WORD_W-1:0] r_rd_front, r_rd_rear;
    logic signed [WORD_W-1:0] r_front, r_rear;
    logic                     r_is_empty, r_is_full;
    t_status                  r_out_status;

    logic [IW-1:0] head_next, head_prev, tail_next, tail_prev;
    logic          full;
    logic          mem_we;
    logic [IW-1:0] mem_wa;

    assign head_next = (r_head == LAST) ? '0 : r_head + 1'b1;
    assign head_prev = (r_head == '0) ? LAST : r_head - 1'b1;
    assign tail_next = (r_tail == LAST) ? '0 : r_tail + 1'b1;
    assign tail_prev = (r_tail == '0) ? LAST : r_tail - 1'b1;
    assign full      = !r_empty && (tail_next == r_head);

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_empty  = r_empty;
        n_status = ST_DONE;
        mem_we   = 1'b0;
        mem_wa   = '0;
        unique case (r_req)
            REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
                if (full) begin
                    n_status = ST_FULL;
                end else if (r_empty) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_empty = 1'b0;
                    mem_we  = 1'b1;
                end else if (r_req == REQ_PUSH_FRONT) begin
                    n_head = head_prev;
                    mem_we = 1'b1;
                    mem_wa = head_prev;
                end else begin
                    n_tail = tail_next;
                    mem_we = 1'b1;
                    mem_wa = tail_next;
                end
            end
            REQ_POP_FRONT, REQ_POP_REAR: begin
                if (r_empty) begin
                    n_status = ST_EMPTY;
                end else if (r_head == r_tail) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_empty = 1'b1;
                end else if (r_req == REQ_POP_FRONT) begin
                    n_head = head_next;
                end else begin
                    n_tail = tail_prev;
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req  <= i_req_type;
            r_data <= i_data_in;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && mem_we) begin
            r_mem[mem_wa] <= r_data;
        end
        if (i_cmd.read) begin
            r_rd_front <= r_mem[r_head];
            r_rd_rear  <= r_mem[r_tail];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_front      <= r_empty ? '0 : r_rd_front;
            r_rear       <= r_empty ? '0 : r_rd_rear;
            r_is_empty   <= r_empty;
            r_is_full    <= full;
            r_out_status <= r_status;
        end
    end

    assign o_front_word = r_front;
    assign o_rear_word  = r_rear;
    assign o_is_empty   = r_is_empty;
    assign o_is_full    = r_is_full;
    assign o_status     = r_out_status;

endmodule

@@ rtl/circular_deque.sv @@
// Double-ended queue of signed 32-bit words in a circular store of DEPTH
// entries. Each request holds the block through capture, pointer update and
// store write, store read and result load, set by the sequencer and the
// registered read of the two-port store; a new request is taken in the cycle
// after the previous result is loaded, while that result may still wait at
// the output, and a ready result holds in the load step while the previous
// one is still stalled. Empty queues report zero words.
module circular_deque
    import dq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [2:0]               i_req_type,
    input  logic signed [WORD_W-1:0] i_data_in,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [WORD_W-1:0] o_front_word,
    output logic signed [WORD_W-1:0] o_rear_word,
    output logic                     o_is_empty,
    output logic                     o_is_full,
    output logic [1:0]               o_status
);

    t_dp_cmd cmd;

    dq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_req_type   (i_req_type),
        .i_data_in    (i_data_in),
        .o_front_word (o_front_word),
        .o_rear_word  (o_rear_word),
        .o_is_empty   (o_is_empty),
        .o_is_full    (o_is_full),
        .o_status     (o_status)
    );

endmodule

@@ rtl/dq_checker.sv @@
// Port-level checks for circular_deque, bound to the top level.
// Depends on dq_pkg.
module dq_checker
    import dq_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_valid,
    input logic                     i_stall,
    input logic signed [WORD_W-1:0] o_front_word,
    input logic signed [WORD_W-1:0] o_rear_word,
    input logic                     o_is_empty,
    input logic                     o_is_full,
    input logic [1:0]               o_status
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_empty |-> o_front_word == '0 && o_rear_word == '0)
        else $error("empty deque reports nonzero words");

    a_empty_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_is_empty && o_is_full))
        else $error("deque both empty and full");

    a_pop_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EMPTY |-> o_is_empty)
        else $error("pop refused on non-empty deque");

    a_push_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_is_full)
        else $error("push refused on non-full deque");

endmodule

bind circular_deque dq_checker u_dq_checker (.*);
